// ===== rtl/core/pps_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the platform power sequencer.
// No dependencies; imported by every module of the block.
package pps_pkg;

  localparam int PPS_COUNT_BITS = 16;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PGOOD_TIMEOUT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RSMRST_DELAY  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FCH_DELAY     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LATE_DELAY    = 8'd3;

  localparam logic [CFG_W-1:0] PGOOD_TIMEOUT_RST = 16'd100;
  localparam logic [CFG_W-1:0] RSMRST_DELAY_RST  = 16'd10;
  localparam logic [CFG_W-1:0] FCH_DELAY_RST     = 16'd10;
  localparam logic [CFG_W-1:0] LATE_DELAY_RST    = 16'd140;

  typedef enum logic [3:0] {
    ST_G3   = 4'd0,
    ST_G3S5 = 4'd1,
    ST_S5   = 4'd2,
    ST_S5S3 = 4'd3,
    ST_S3   = 4'd4,
    ST_S3S0 = 4'd5,
    ST_S0   = 4'd6,
    ST_S0S3 = 4'd7,
    ST_S3S5 = 4'd8,
    ST_S5G3 = 4'd9
  } pps_state_t;

  typedef enum logic [2:0] {
    HOOK_NONE     = 3'd0,
    HOOK_STARTUP  = 3'd1,
    HOOK_RESUME   = 3'd2,
    HOOK_SUSPEND  = 3'd3,
    HOOK_SHUTDOWN = 3'd4
  } pps_hook_t;

  typedef struct packed {
    logic pgood_s5;
    logic pgood_core;
    logic slp_s5_l;
    logic slp_s3_l;
    logic power_on_req;
    logic force_shutdown_req;
  } pps_in_t;

  typedef struct packed {
    logic [3:0] sys_state;
    logic       always_rails_en;
    logic       resume_rst_l;
    logic       usb_switch_to_fch;
    logic       pson_l;
    logic       usb_power_l;
    logic       fch_pwrgd;
    logic       late_pwrgd;
    logic       pass_slp_s5_l;
    logic       pass_slp_s3_l;
    logic       pch_power_button;
    logic [2:0] hook_event;
  } pps_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] pgood_timeout_ticks;
    logic [CFG_W-1:0] rsmrst_delay_ticks;
    logic [CFG_W-1:0] fch_pwrgd_delay_ticks;
    logic [CFG_W-1:0] late_pwrgd_delay_ticks;
  } pps_cfg_t;

  typedef struct packed {
    logic rails_en;
    logic resume_rst_l;
    logic usb_sw;
    logic pson_l;
    logic usb_power_l;
    logic fch_pwrgd;
    logic late_pwrgd;
    logic button;
  } pps_pins_t;

  localparam pps_pins_t PINS_G3 = '{
    rails_en: 1'b0, resume_rst_l: 1'b0, usb_sw: 1'b0, pson_l: 1'b1,
    usb_power_l: 1'b1, fch_pwrgd: 1'b0, late_pwrgd: 1'b0, button: 1'b0
  };

  // Pin actions decided by the sequencing step
  typedef struct packed {
    logic rails_on;
    logic to_g3;
    logic s5_ready;
    logic s3_entry;
    logic fch_on;
    logic late_on;
    logic s0_exit;
    logic s5_exit;
  } pps_evt_t;

endpackage

// ===== rtl/core/pps_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file for the power sequencer (delays and timeout).
// Depends on pps_pkg.
module pps_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pps_pkg::CFG_W-1:0]      cfg_data,
  output pps_pkg::pps_cfg_t              cfg
);
  import pps_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pgood_timeout_ticks    <= PGOOD_TIMEOUT_RST;
      cfg.rsmrst_delay_ticks     <= RSMRST_DELAY_RST;
      cfg.fch_pwrgd_delay_ticks  <= FCH_DELAY_RST;
      cfg.late_pwrgd_delay_ticks <= LATE_DELAY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_PGOOD_TIMEOUT: cfg.pgood_timeout_ticks    <= cfg_data;
        CFG_IDX_RSMRST_DELAY:  cfg.rsmrst_delay_ticks     <= cfg_data;
        CFG_IDX_FCH_DELAY:     cfg.fch_pwrgd_delay_ticks  <= cfg_data;
        CFG_IDX_LATE_DELAY:    cfg.late_pwrgd_delay_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/pps_seq.sv =====
`timescale 1ns / 1ps
// Sleep-state sequencer: state, wait counter, pin levels and one-tick step logic.
// Depends on pps_pkg.
module pps_seq #(
  parameter int COUNT_BITS = pps_pkg::PPS_COUNT_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  pps_pkg::pps_in_t  item,
  input  pps_pkg::pps_cfg_t cfg,
  output pps_pkg::pps_out_t result
);
  import pps_pkg::*;

  localparam int LW = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [LW-1:0] CNT_MAX_EXT = LW'(CNT_MAX);

  localparam logic [1:0] PH_PGOOD   = 2'd0;
  localparam logic [1:0] PH_DELAY_A = 2'd1;
  localparam logic [1:0] PH_DELAY_B = 2'd2;

  pps_state_t            st, st_next;
  logic [1:0]            sub, sub_next;
  logic [COUNT_BITS-1:0] wc, wc_next;
  logic                  forcing, forcing_next;
  pps_pins_t             pins, pins_next;
  pps_evt_t              evt;
  pps_hook_t             hook;

  logic [COUNT_BITS-1:0] lim_to, lim_rs, lim_fch, lim_late;

  // Register values beyond the counter range saturate at its maximum
  function automatic logic [COUNT_BITS-1:0] clamp(input logic [CFG_W-1:0] v);
    logic [LW-1:0] ve;
    ve = LW'(v);
    if (ve > CNT_MAX_EXT) return CNT_MAX;
    return ve[COUNT_BITS-1:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == CNT_MAX) ? c : c + COUNT_BITS'(1);
  endfunction

  assign lim_to   = clamp(cfg.pgood_timeout_ticks);
  assign lim_rs   = clamp(cfg.rsmrst_delay_ticks);
  assign lim_fch  = clamp(cfg.fch_pwrgd_delay_ticks);
  assign lim_late = clamp(cfg.late_pwrgd_delay_ticks);

  // Next state, phase and counter
  always_comb begin
    logic [COUNT_BITS-1:0] c;
    logic [1:0]            ph;
    logic                  go;
    logic                  stop;
    st_next  = st;
    sub_next = sub;
    wc_next  = wc;
    evt      = '0;
    c        = wc;
    ph       = sub;
    go       = 1'b0;
    stop     = 1'b0;
    case (st)
      ST_G3: begin
        if (item.power_on_req) begin
          st_next = ST_G3S5; sub_next = PH_PGOOD; wc_next = '0;
        end
      end
      ST_G3S5: begin
        if (sub == PH_PGOOD) begin
          evt.rails_on = 1'b1;
          if (item.pgood_s5) begin
            c  = '0;
            go = 1'b1;
          end else begin
            c = sat_inc(wc);
            if (c >= lim_to) begin
              evt.to_g3 = 1'b1;
              st_next = ST_G3; sub_next = PH_PGOOD; wc_next = '0;
            end else begin
              wc_next = c;
            end
          end
        end else begin
          go = 1'b1;
        end
        if (go) begin
          if (c >= lim_rs) begin
            evt.s5_ready = 1'b1;
            st_next = ST_S5; sub_next = PH_PGOOD; wc_next = '0;
          end else begin
            wc_next  = sat_inc(c);
            sub_next = PH_DELAY_A;
          end
        end
      end
      ST_S5: begin
        if (!item.pgood_s5) begin
          st_next = ST_S5G3; sub_next = PH_PGOOD; wc_next = '0;
        end else if (item.slp_s5_l) begin
          st_next = ST_S5S3; sub_next = PH_PGOOD; wc_next = '0;
        end
      end
      ST_S5S3: begin
        sub_next = PH_PGOOD;
        wc_next  = '0;
        if (!item.pgood_s5) begin
          st_next = ST_S5G3;
        end else begin
          evt.s3_entry = 1'b1;
          st_next = ST_S3;
        end
      end
      ST_S3: begin
        if (!item.pgood_s5) begin
          st_next = ST_S5G3; sub_next = PH_PGOOD; wc_next = '0;
        end else if (item.slp_s3_l) begin
          st_next = ST_S3S0; sub_next = PH_PGOOD; wc_next = '0;
        end else if (!item.slp_s5_l) begin
          st_next = ST_S3S5; sub_next = PH_PGOOD; wc_next = '0;
        end
      end
      ST_S3S0: begin
        // Up to three phases can resolve in one tick when delays are zero
        if (ph == PH_PGOOD) begin
          if (!item.pgood_s5) begin
            st_next = ST_S5G3; sub_next = PH_PGOOD; wc_next = '0;
            stop = 1'b1;
          end else if (item.pgood_core) begin
            ph = PH_DELAY_A;
            c  = '0;
          end else begin
            c = sat_inc(wc);
            if (c >= lim_to) begin
              st_next = ST_S5G3; sub_next = PH_PGOOD; wc_next = '0;
            end else begin
              wc_next = c;
            end
            stop = 1'b1;
          end
        end
        if (!stop && ph == PH_DELAY_A) begin
          if (c >= lim_fch) begin
            evt.fch_on = 1'b1;
            ph = PH_DELAY_B;
            c  = '0;
          end else begin
            wc_next  = sat_inc(c);
            sub_next = PH_DELAY_A;
            stop     = 1'b1;
          end
        end
        if (!stop) begin
          if (c >= lim_late) begin
            evt.late_on = 1'b1;
            st_next = ST_S0; sub_next = PH_PGOOD; wc_next = '0;
          end else begin
            wc_next  = sat_inc(c);
            sub_next = PH_DELAY_B;
          end
        end
      end
      ST_S0: begin
        if (!item.pgood_s5) begin
          st_next = ST_S5G3; sub_next = PH_PGOOD; wc_next = '0;
        end else if (!item.slp_s3_l) begin
          st_next = ST_S0S3; sub_next = PH_PGOOD; wc_next = '0;
        end
      end
      ST_S0S3: begin
        evt.s0_exit = 1'b1;
        st_next = ST_S3; sub_next = PH_PGOOD; wc_next = '0;
      end
      ST_S3S5: begin
        evt.s5_exit = 1'b1;
        st_next = ST_S5; sub_next = PH_PGOOD; wc_next = '0;
      end
      default: begin
        evt.to_g3 = 1'b1;
        st_next = ST_G3; sub_next = PH_PGOOD; wc_next = '0;
      end
    endcase
  end

  // Pin levels, forced-shutdown button and hook code
  always_comb begin
    logic press;
    logic release_btn;
    pins_next    = pins;
    forcing_next = forcing;
    hook         = HOOK_NONE;
    release_btn  = (st == ST_S5) && forcing;
    press        = item.force_shutdown_req && (st != ST_G3) && (st != ST_G3S5) &&
                   (st != ST_S5) && (st != ST_S5G3);
    if (release_btn) begin
      pins_next.button = 1'b0;
      forcing_next     = 1'b0;
    end
    if (press) begin
      pins_next.button = 1'b1;
      forcing_next     = 1'b1;
    end
    if (evt.rails_on) pins_next.rails_en = 1'b1;
    if (evt.to_g3) begin
      pins_next        = PINS_G3;
      pins_next.button = (release_btn && !press) ? 1'b0 : (pins.button || press);
    end
    if (evt.s5_ready) begin
      pins_next.resume_rst_l = 1'b1;
      pins_next.usb_sw       = 1'b1;
    end
    if (evt.s3_entry) begin
      pins_next.usb_power_l = 1'b0;
      pins_next.pson_l      = 1'b0;
      hook                  = HOOK_STARTUP;
    end
    if (evt.fch_on) pins_next.fch_pwrgd = 1'b1;
    if (evt.late_on) begin
      pins_next.late_pwrgd = 1'b1;
      hook                 = HOOK_RESUME;
    end
    if (evt.s0_exit) begin
      pins_next.late_pwrgd = 1'b0;
      pins_next.fch_pwrgd  = 1'b0;
      hook                 = HOOK_SUSPEND;
    end
    if (evt.s5_exit) begin
      pins_next.pson_l      = 1'b1;
      pins_next.usb_power_l = 1'b1;
      hook                  = HOOK_SHUTDOWN;
    end
  end

  always_comb begin
    result.sys_state         = st_next;
    result.always_rails_en   = pins_next.rails_en;
    result.resume_rst_l      = pins_next.resume_rst_l;
    result.usb_switch_to_fch = pins_next.usb_sw;
    result.pson_l            = pins_next.pson_l;
    result.usb_power_l       = pins_next.usb_power_l;
    result.fch_pwrgd         = pins_next.fch_pwrgd;
    result.late_pwrgd        = pins_next.late_pwrgd;
    result.pass_slp_s5_l     = item.slp_s5_l;
    result.pass_slp_s3_l     = item.slp_s3_l;
    result.pch_power_button  = pins_next.button;
    result.hook_event        = hook;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= ST_G3;
      sub     <= PH_PGOOD;
      wc      <= '0;
      forcing <= 1'b0;
      pins    <= PINS_G3;
    end else if (step) begin
      st      <= st_next;
      sub     <= sub_next;
      wc      <= wc_next;
      forcing <= forcing_next;
      pins    <= pins_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_button_tracks_forcing: assert property (@(posedge clk) disable iff (rst)
    forcing == pins.button)
    else $error("button level disagrees with forced-shutdown flag");

  a_stable_state_counter_idle: assert property (@(posedge clk) disable iff (rst)
    (st == ST_G3 || st == ST_S5 || st == ST_S3 || st == ST_S0) |-> (wc == '0 && sub == PH_PGOOD))
    else $error("wait counter or phase not clear in a steady state");

  a_late_needs_fch: assert property (@(posedge clk) disable iff (rst)
    pins.late_pwrgd |-> pins.fch_pwrgd)
    else $error("late power good without FCH power good");

  a_fch_needs_pson: assert property (@(posedge clk) disable iff (rst)
    pins.fch_pwrgd |-> !pins.pson_l)
    else $error("FCH power good while main supply is off");
`endif

endmodule

// ===== rtl/core/platform_power_sequencer.sv =====
`timescale 1ns / 1ps
// Top level of the platform power sequencer: input stage, result register, handshakes.
// Depends on pps_pkg, pps_cfg_regs and pps_seq.

// One item is one timer tick. The block accepts an item every clock cycle while
// its result is not stalled, and returns one result item per tick: the tick waits
// in an input register, the combinational sequencing step (state, wait counter,
// pin levels) turns it into a result, and the result sits in an output register
// until taken. The step registers the result once the output register is free or
// being taken. A stalled result holds the input register, so at most two ticks
// are in flight. The step updates the state registers at the same edge that
// captures the result, so back-to-back ticks see each other's state updates.
// sys_state and the pin fields give levels after the tick.
// Configuration writes are always ready and take effect at once; write only while idle.
module platform_power_sequencer #(
  parameter int COUNT_BITS = pps_pkg::PPS_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pps_pkg::pps_in_t              in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pps_pkg::pps_out_t             out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pps_pkg::CFG_W-1:0]     cfg_data
);
  import pps_pkg::*;

  logic      held_valid;
  pps_in_t   held_item;
  logic      step;
  pps_cfg_t  cfg;
  pps_out_t  result;

  assign step     = held_valid && (!out_valid || out_ready);
  assign in_ready = !held_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= result;
    end
  end

  pps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pps_seq #(
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (held_item),
    .cfg    (cfg),
    .result (result)
  );

endmodule

// ===== bench/tb_platform_power_sequencer.sv =====
`timescale 1ns / 1ps
// Testbench for platform_power_sequencer: directed and random tick streams through
// G3/S5/S3/S0, each result checked against an in-bench model of the sequencer.
// Depends on pps_pkg and the platform_power_sequencer RTL.
module tb_platform_power_sequencer;
  import pps_pkg::*;

  localparam int unsigned RUN_LIMIT_NS = 4_000_000;
  localparam longint unsigned CNT_MAX = (64'd1 << PPS_COUNT_BITS) - 1;

  typedef enum logic [1:0] {RCV_ALWAYS, RCV_HALF, RCV_THIRD, RCV_MOSTLY} rcv_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  pps_in_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pps_out_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // sequencer model state
  pps_cfg_t cfg_model;
  pps_state_t seq_st;
  logic [1:0] sub_ph;
  longint unsigned wait_cnt;
  logic forcing;
  pps_pins_t pins;

  pps_in_t tick_q[$];
  pps_out_t expected_q[$];

  int unsigned n_queued = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned n_settings = 0;
  bit noisy = 1'b0;
  bit [15:0] states_seen = '0;
  bit [7:0] hooks_seen = '0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  int unsigned ready_phase = 0;
  int unsigned n_taken = 0;
  bit long_hold_done = 1'b0;
  rcv_mode_t rcv_mode = RCV_ALWAYS;

  platform_power_sequencer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic longint unsigned clamp_count(input logic [CFG_W-1:0] v);
    return (v > CNT_MAX) ? CNT_MAX : longint'(v);
  endfunction

  function automatic void enter_state(input pps_state_t s);
    seq_st = s;
    sub_ph = 2'd0;
    wait_cnt = 0;
  endfunction

  function automatic void drop_pins_to_g3();
    logic held;
    held = pins.button;
    pins = PINS_G3;
    pins.button = held;
  endfunction

  // true once the delay has run out; the tick that starts the delay is tick 0
  function automatic bit delay_elapsed(input logic [CFG_W-1:0] lim);
    if (wait_cnt >= clamp_count(lim)) return 1'b1;
    if (wait_cnt < CNT_MAX) wait_cnt++;
    return 1'b0;
  endfunction

  function automatic bit pgood_timed_out();
    if (wait_cnt < CNT_MAX) wait_cnt++;
    return wait_cnt >= clamp_count(cfg_model.pgood_timeout_ticks);
  endfunction

  function automatic pps_out_t sequence_tick(input pps_in_t t);
    pps_out_t r;
    pps_hook_t hook;
    bit go;
    hook = HOOK_NONE;
    go = 1'b1;
    if (seq_st == ST_S5 && forcing) begin
      pins.button = 1'b0;
      forcing = 1'b0;
    end
    // forced shutdown only means something once the main supply may be up
    if (t.force_shutdown_req && seq_st != ST_G3 && seq_st != ST_G3S5 &&
        seq_st != ST_S5 && seq_st != ST_S5G3) begin
      forcing = 1'b1;
      pins.button = 1'b1;
    end
    case (seq_st)
      ST_G3: begin
        if (t.power_on_req) enter_state(ST_G3S5);
      end
      ST_G3S5: begin
        if (sub_ph == 2'd0) begin
          pins.rails_en = 1'b1;
          if (t.pgood_s5) begin
            sub_ph = 2'd1;
            wait_cnt = 0;
          end else begin
            go = 1'b0;
            if (pgood_timed_out()) begin
              drop_pins_to_g3();
              enter_state(ST_G3);
            end
          end
        end
        if (go && delay_elapsed(cfg_model.rsmrst_delay_ticks)) begin
          pins.resume_rst_l = 1'b1;
          pins.usb_sw = 1'b1;
          enter_state(ST_S5);
        end
      end
      ST_S5: begin
        if (!t.pgood_s5) enter_state(ST_S5G3);
        else if (t.slp_s5_l) enter_state(ST_S5S3);
      end
      ST_S5S3: begin
        if (!t.pgood_s5) begin
          enter_state(ST_S5G3);
        end else begin
          pins.usb_power_l = 1'b0;
          pins.pson_l = 1'b0;
          hook = HOOK_STARTUP;
          enter_state(ST_S3);
        end
      end
      ST_S3: begin
        if (!t.pgood_s5) enter_state(ST_S5G3);
        else if (t.slp_s3_l) enter_state(ST_S3S0);
        else if (!t.slp_s5_l) enter_state(ST_S3S5);
      end
      ST_S3S0: begin
        if (sub_ph == 2'd0) begin
          if (!t.pgood_s5) begin
            go = 1'b0;
            enter_state(ST_S5G3);
          end else if (t.pgood_core) begin
            sub_ph = 2'd1;
            wait_cnt = 0;
          end else begin
            go = 1'b0;
            if (pgood_timed_out()) enter_state(ST_S5G3);
          end
        end
        if (go && sub_ph == 2'd1) begin
          if (!delay_elapsed(cfg_model.fch_pwrgd_delay_ticks)) begin
            go = 1'b0;
          end else begin
            pins.fch_pwrgd = 1'b1;
            sub_ph = 2'd2;
            wait_cnt = 0;
          end
        end
        if (go && delay_elapsed(cfg_model.late_pwrgd_delay_ticks)) begin
          pins.late_pwrgd = 1'b1;
          hook = HOOK_RESUME;
          enter_state(ST_S0);
        end
      end
      ST_S0: begin
        if (!t.pgood_s5) enter_state(ST_S5G3);
        else if (!t.slp_s3_l) enter_state(ST_S0S3);
      end
      ST_S0S3: begin
        hook = HOOK_SUSPEND;
        pins.late_pwrgd = 1'b0;
        pins.fch_pwrgd = 1'b0;
        enter_state(ST_S3);
      end
      ST_S3S5: begin
        hook = HOOK_SHUTDOWN;
        pins.pson_l = 1'b1;
        pins.usb_power_l = 1'b1;
        enter_state(ST_S5);
      end
      default: begin
        drop_pins_to_g3();
        enter_state(ST_G3);
      end
    endcase
    r.sys_state = seq_st;
    r.always_rails_en = pins.rails_en;
    r.resume_rst_l = pins.resume_rst_l;
    r.usb_switch_to_fch = pins.usb_sw;
    r.pson_l = pins.pson_l;
    r.usb_power_l = pins.usb_power_l;
    r.fch_pwrgd = pins.fch_pwrgd;
    r.late_pwrgd = pins.late_pwrgd;
    r.pass_slp_s5_l = t.slp_s5_l;
    r.pass_slp_s3_l = t.slp_s3_l;
    r.pch_power_button = pins.button;
    r.hook_event = hook;
    return r;
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : driver
    bit next_valid;
    next_valid = in_valid;
    if (rst) begin
      next_valid = 1'b0;
      gap_left = 0;
      burst_left = $urandom_range(1, 40);
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(sequence_tick(in_item));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (tick_q.size() > 0) begin
          in_item <= tick_q.pop_front();
          next_valid = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
    in_valid <= next_valid;
  end

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin : receiver
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) n_taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && n_taken >= 200) begin
        // long back-pressure so the block fills and stalls its input
        long_hold_done = 1'b1;
        hold_left = 150;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rcv_mode = rcv_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        ready_phase++;
        case (rcv_mode)
          RCV_ALWAYS: out_ready <= 1'b1;
          RCV_HALF:   out_ready <= 1'($urandom_range(0, 1));
          RCV_THIRD:  out_ready <= (ready_phase % 3 == 0);
          default:    out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(input string what, input logic [3:0] want,
                             input logic [3:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    pps_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        n_errors++;
        $display("%0t: result with no tick outstanding, expected none, actual %h",
                 $time, out_item);
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        states_seen[want.sys_state] = 1'b1;
        hooks_seen[want.hook_event] = 1'b1;
        check_field("sys_state", want.sys_state, out_item.sys_state);
        check_field("always_rails_en", 4'(want.always_rails_en),
                    4'(out_item.always_rails_en));
        check_field("resume_rst_l", 4'(want.resume_rst_l), 4'(out_item.resume_rst_l));
        check_field("usb_switch_to_fch", 4'(want.usb_switch_to_fch),
                    4'(out_item.usb_switch_to_fch));
        check_field("pson_l", 4'(want.pson_l), 4'(out_item.pson_l));
        check_field("usb_power_l", 4'(want.usb_power_l), 4'(out_item.usb_power_l));
        check_field("fch_pwrgd", 4'(want.fch_pwrgd), 4'(out_item.fch_pwrgd));
        check_field("late_pwrgd", 4'(want.late_pwrgd), 4'(out_item.late_pwrgd));
        check_field("pass_slp_s5_l", 4'(want.pass_slp_s5_l), 4'(out_item.pass_slp_s5_l));
        check_field("pass_slp_s3_l", 4'(want.pass_slp_s3_l), 4'(out_item.pass_slp_s3_l));
        check_field("pch_power_button", 4'(want.pch_power_button),
                    4'(out_item.pch_power_button));
        check_field("hook_event", 4'(want.hook_event), 4'(out_item.hook_event));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic bit coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic int unsigned capped(input int unsigned v, input int unsigned c);
    return (v > c) ? c : v;
  endfunction

  // args: pgood_s5, pgood_core, slp_s5_l, slp_s3_l, power_on_req, force_shutdown_req
  task automatic queue_tick(input bit pg5, input bit pgc, input bit s5l, input bit s3l,
                            input bit pon, input bit frc);
    pps_in_t t;
    if (noisy && $urandom_range(0, 24) == 0) begin
      t = pps_in_t'(6'($urandom_range(0, 63)));
    end else begin
      t.pgood_s5 = pg5;
      t.pgood_core = pgc;
      t.slp_s5_l = s5l;
      t.slp_s3_l = s3l;
      t.power_on_req = pon;
      t.force_shutdown_req = frc;
    end
    tick_q.push_back(t);
    n_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_valid || expected_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_IDX_PGOOD_TIMEOUT: cfg_model.pgood_timeout_ticks = val;
      CFG_IDX_RSMRST_DELAY:  cfg_model.rsmrst_delay_ticks = val;
      CFG_IDX_FCH_DELAY:     cfg_model.fch_pwrgd_delay_ticks = val;
      CFG_IDX_LATE_DELAY:    cfg_model.late_pwrgd_delay_ticks = val;
      default: ;
    endcase
  endtask

  task automatic set_registers(input logic [CFG_W-1:0] tmo, input logic [CFG_W-1:0] rsm,
                               input logic [CFG_W-1:0] fch, input logic [CFG_W-1:0] late);
    write_reg(CFG_IDX_PGOOD_TIMEOUT, tmo);
    write_reg(CFG_IDX_RSMRST_DELAY, rsm);
    write_reg(CFG_IDX_FCH_DELAY, fch);
    write_reg(CFG_IDX_LATE_DELAY, late);
    n_settings++;
    @(negedge clk);
  endtask

  // One pass G3 -> S5 -> S3 -> (S0 -> S3) -> S5 with random detours; fields the
  // current state ignores are random. Waits are sized from the live settings.
  task automatic power_cycle();
    int unsigned tmo, rsm, fch, late, n;
    tmo = 32'(cfg_model.pgood_timeout_ticks);
    rsm = 32'(cfg_model.rsmrst_delay_ticks);
    fch = 32'(cfg_model.fch_pwrgd_delay_ticks);
    late = 32'(cfg_model.late_pwrgd_delay_ticks);
    // drop S5 power to get back to G3
    repeat ($urandom_range(2, 3)) queue_tick(0, coin(), 0, 0, 0, 0);
    queue_tick(coin(), coin(), 0, coin(), 1, 0);
    if ($urandom_range(0, 7) == 0) begin
      // S5 rail never comes up
      repeat (capped(tmo, 300) + 2) queue_tick(0, coin(), coin(), coin(), coin(), coin());
    end else begin
      n = (tmo > 1) ? $urandom_range(0, capped(tmo - 1, 6)) : 0;
      repeat (n) queue_tick(0, coin(), 0, coin(), coin(), coin());
      repeat (capped(rsm, 300) + 2) queue_tick(1, coin(), 0, coin(), coin(), 0);
      repeat ($urandom_range(0, 3)) queue_tick(1, coin(), 0, coin(), coin(), coin());
      repeat (2) queue_tick(1, coin(), 1, 0, coin(), 0);
      if ($urandom_range(0, 3) != 0) begin
        queue_tick(1, coin(), 1, 1, coin(), 0);
        if ($urandom_range(0, 7) == 0) begin
          // core rails never come up
          repeat (capped(tmo, 300) + 2) queue_tick(1, 0, 1, 1, coin(), 0);
        end else begin
          n = (tmo > 1) ? $urandom_range(0, capped(tmo - 1, 6)) : 0;
          repeat (n) queue_tick(1, 0, 1, 1, coin(), 0);
          repeat (capped(fch, 300) + capped(late, 300) + 2) queue_tick(1, 1, 1, 1, coin(), 0);
          repeat ($urandom_range(1, 12))
            queue_tick(1, coin(), 1, 1, coin(), $urandom_range(0, 24) == 0);
          if ($urandom_range(0, 5) != 0) begin
            repeat (2) queue_tick(1, coin(), 1, 0, coin(), 0);
            if (coin()) repeat (2) queue_tick(1, coin(), 0, 0, coin(), 0);
          end
        end
      end else begin
        repeat (2) queue_tick(1, coin(), 0, 0, coin(), 0);
      end
      // in S5 a held power button is let go
      queue_tick(1, coin(), 0, coin(), coin(), coin());
    end
  endtask

  task automatic power_cycles(input int unsigned count);
    int unsigned start;
    start = n_queued;
    while (n_queued - start < count) power_cycle();
    wait_idle();
  endtask

  initial begin : stimulus
    cfg_model.pgood_timeout_ticks = PGOOD_TIMEOUT_RST;
    cfg_model.rsmrst_delay_ticks = RSMRST_DELAY_RST;
    cfg_model.fch_pwrgd_delay_ticks = FCH_DELAY_RST;
    cfg_model.late_pwrgd_delay_ticks = LATE_DELAY_RST;
    seq_st = ST_G3;
    sub_ph = 2'd0;
    wait_cnt = 0;
    forcing = 1'b0;
    pins = PINS_G3;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed walk with short delays
    set_registers(16'd2, 16'd0, 16'd0, 16'd1);
    queue_tick(0, 0, 0, 0, 0, 1);  // forced shutdown ignored in G3
    queue_tick(0, 0, 0, 0, 1, 0);  // G3 -> G3S5
    queue_tick(0, 0, 0, 0, 0, 0);
    queue_tick(0, 0, 0, 0, 0, 0);  // S5 power good timeout -> G3
    queue_tick(1, 1, 1, 1, 1, 0);
    queue_tick(1, 0, 0, 0, 0, 0);  // RSMRST released -> S5
    queue_tick(1, 0, 0, 0, 0, 1);  // forced shutdown ignored in S5
    queue_tick(1, 0, 1, 0, 0, 0);  // -> S5S3
    queue_tick(1, 0, 1, 0, 0, 0);  // -> S3, startup
    queue_tick(1, 0, 0, 0, 0, 0);  // -> S3S5
    queue_tick(1, 0, 0, 0, 0, 0);  // -> S5, shutdown with USB power off
    queue_tick(1, 0, 1, 0, 0, 0);
    queue_tick(1, 0, 1, 0, 0, 0);
    queue_tick(1, 1, 1, 1, 0, 0);  // -> S3S0
    queue_tick(1, 1, 1, 1, 0, 0);
    queue_tick(1, 1, 1, 1, 0, 0);  // -> S0, resume
    queue_tick(1, 1, 1, 1, 0, 1);  // button pressed in S0
    queue_tick(1, 1, 1, 0, 0, 0);  // -> S0S3
    queue_tick(1, 1, 1, 0, 0, 0);  // -> S3, suspend
    queue_tick(1, 0, 1, 1, 0, 0);
    queue_tick(1, 0, 1, 1, 0, 0);
    queue_tick(1, 0, 1, 1, 0, 0);  // core timeout -> S5G3
    queue_tick(1, 0, 0, 0, 0, 0);  // -> G3, button stays held
    queue_tick(0, 0, 0, 0, 1, 0);
    queue_tick(1, 0, 0, 0, 0, 0);  // -> S5
    queue_tick(1, 0, 0, 0, 0, 0);  // button released
    queue_tick(0, 1, 1, 1, 1, 1);
    wait_idle();

    noisy = 1'b1;
    set_registers(PGOOD_TIMEOUT_RST, RSMRST_DELAY_RST, FCH_DELAY_RST, LATE_DELAY_RST);
    power_cycles(450);

    set_registers(16'd0, 16'd0, 16'd0, 16'd0);
    power_cycles(250);

    set_registers(16'($urandom_range(1, 12)), 16'($urandom_range(0, 8)),
                  16'($urandom_range(0, 8)), 16'($urandom_range(0, 20)));
    power_cycles(350);
    repeat (60) queue_tick(coin(), coin(), coin(), coin(), coin(), coin());
    wait_idle();

    // largest settings: no wait runs out here, the next setting cuts it short
    set_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (30) queue_tick(0, coin(), coin(), coin(), 1, coin());
    repeat (120) queue_tick(1, coin(), coin(), coin(), coin(), coin());
    wait_idle();

    set_registers(16'd1, 16'd1, 16'd2, 16'd3);
    power_cycles(300);

    repeat (5) @(posedge clk);
    $display("Checked %0d ticks over %0d register settings, %0d mismatches.",
             n_checked, n_settings, n_errors);
    $display("States reached %b, hook events reported %b.", states_seen[9:0],
             hooks_seen[4:0]);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
